// ===== design/nls_pkg.sv =====
// Shared types and codes for the nearest level search block.
package nls_pkg;

  // Input opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CK_LO,
    S_CK_HI,
    S_MID,
    S_CK_MID,
    S_CK_NBL,
    S_CK_NBH,
    S_DONE
  } nls_state_e;

  // Table read address source
  typedef enum logic [2:0] {
    RD_ZERO,
    RD_LAST,
    RD_MID,
    RD_MIDM1,
    RD_MIDP1
  } nls_rd_sel_e;

  // Result source
  typedef enum logic [2:0] {
    RES_ZERO,
    RES_LAST,
    RES_MID,
    RES_PICK_LO,
    RES_PICK_HI
  } nls_res_sel_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic         wr_en;
    logic         load_query;
    logic         rd_en;
    nls_rd_sel_e  rd_sel;
    logic         init_ij;
    logic         set_j_mid;
    logic         set_i_mid1;
    logic         load_mid;
    logic         save_m;
    logic         res_load;
    nls_res_sel_e res_sel;
    logic         out_load;
  } nls_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic v_le;
    logic v_ge;
    logic v_eq;
    logic v_lt;
    logic v_gt;
    logic i_lt_j;
    logic mid_gt0;
    logic mid_lt_last;
    logic out_free;
  } nls_status_t;

endpackage

// ===== design/nls_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module nls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/nls_ctrl.sv =====
// Controller state machine for the nearest level search.
module nls_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                opcode_i,
  output logic                in_ready_o,
  input  nls_pkg::nls_status_t status_i,
  output nls_pkg::nls_cmd_t   cmd_o
);
  import nls_pkg::*;

  nls_state_e state_q, state_d;
  logic       in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (opcode_i == OP_QUERY)) state_d = S_CK_LO;
      end
      S_CK_LO:  state_d = status_i.v_le ? S_DONE : S_CK_HI;
      S_CK_HI:  state_d = status_i.v_ge ? S_DONE : S_MID;
      S_MID:    state_d = status_i.i_lt_j ? S_CK_MID : S_DONE;
      S_CK_MID: begin
        if (status_i.v_eq) begin
          state_d = S_DONE;
        end else if (status_i.v_lt) begin
          state_d = status_i.mid_gt0 ? S_CK_NBL : S_MID;
        end else begin
          state_d = status_i.mid_lt_last ? S_CK_NBH : S_MID;
        end
      end
      S_CK_NBL: state_d = status_i.v_gt ? S_DONE : S_MID;
      S_CK_NBH: state_d = status_i.v_lt ? S_DONE : S_MID;
      S_DONE: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.rd_sel  = RD_ZERO;
    cmd_o.res_sel = RES_ZERO;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.wr_en = in_fire && (opcode_i == OP_WRITE);
        if (in_fire && (opcode_i == OP_QUERY)) begin
          cmd_o.load_query = 1'b1;
          cmd_o.rd_en      = 1'b1;
          cmd_o.rd_sel     = RD_ZERO;
        end
      end
      S_CK_LO: begin
        if (status_i.v_le) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_ZERO;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LAST;
        end
      end
      S_CK_HI: begin
        if (status_i.v_ge) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_LAST;
        end else begin
          cmd_o.init_ij = 1'b1;
        end
      end
      S_MID: begin
        if (status_i.i_lt_j) begin
          cmd_o.load_mid = 1'b1;
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_sel   = RD_MID;
        end else begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_MID;
        end
      end
      S_CK_MID: begin
        cmd_o.save_m = 1'b1;
        if (status_i.v_eq) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_MID;
        end else if (status_i.v_lt) begin
          if (status_i.mid_gt0) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_MIDM1;
          end else begin
            cmd_o.set_j_mid = 1'b1;
          end
        end else begin
          if (status_i.mid_lt_last) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_MIDP1;
          end else begin
            cmd_o.set_i_mid1 = 1'b1;
          end
        end
      end
      S_CK_NBL: begin
        if (status_i.v_gt) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_PICK_LO;
        end else begin
          cmd_o.set_j_mid = 1'b1;
        end
      end
      S_CK_NBH: begin
        if (status_i.v_lt) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_PICK_HI;
        end else begin
          cmd_o.set_i_mid1 = 1'b1;
        end
      end
      S_DONE: begin
        cmd_o.out_load = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== design/nls_datapath.sv =====
// Datapath of the nearest level search: table RAM, search bounds, compare and result.
module nls_datapath #(
  parameter int LEVELS_MAX = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  nls_pkg::nls_cmd_t      cmd_i,
  output nls_pkg::nls_status_t   status_o,
  input  logic                   cfg_we_i,
  input  logic [8:0]             cfg_data_i,
  input  logic [7:0]             entry_index_i,
  input  logic [VALUE_BITS-1:0]  level_value_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [7:0]             nearest_index_o
);
  import nls_pkg::*;

  localparam int AW = $clog2(LEVELS_MAX);
  localparam int CW = $clog2(LEVELS_MAX + 1);

  logic [8:0]                   count_q;
  logic [CW-1:0]                p_q, p_d;
  logic [CW-1:0]                i_q, j_q;
  logic [AW-1:0]                mid_q, mid_d;
  logic signed [VALUE_BITS-1:0] v_q, m_q, rd_s;
  logic [VALUE_BITS-1:0]        rdata;
  logic [AW-1:0]                res_q, res_d;
  logic                         out_valid_q;
  logic [7:0]                   out_idx_q;
  logic [AW-1:0]                raddr;
  logic [AW-1:0]                waddr;
  logic                         we;
  logic [31:0]                  widx;
  logic [31:0]                  cnt_wide, p_wide, res_wide;
  logic [CW:0]                  ij_sum;
  logic [CW-1:0]                last_idx;
  logic [CW:0]                  mid_p1_wide;
  logic signed [VALUE_BITS-1:0] lo_s, hi_s;
  logic signed [VALUE_BITS+1:0] pair_sum, twice_v;
  logic                         lower_closer;

  // Table write, ignored beyond the table depth
  assign widx  = 32'(entry_index_i);
  assign waddr = widx[AW-1:0];
  assign we    = cmd_i.wr_en && (widx < 32'(LEVELS_MAX));

  // Read address select
  assign last_idx = p_q - CW'(1);
  assign ij_sum   = {1'b0, i_q} + {1'b0, j_q};
  assign mid_d    = ij_sum[AW:1];

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_ZERO:  raddr = '0;
      RD_LAST:  raddr = last_idx[AW-1:0];
      RD_MID:   raddr = mid_d;
      RD_MIDM1: raddr = mid_q - AW'(1);
      RD_MIDP1: raddr = mid_q + AW'(1);
      default:  raddr = '0;
    endcase
  end

  nls_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (LEVELS_MAX)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (level_value_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_s = rdata;

  // Clamp the count in use to one through the table depth
  assign cnt_wide = 32'(count_q);
  always_comb begin
    if (cnt_wide == 32'd0) begin
      p_wide = 32'd1;
    end else if (cnt_wide > 32'(LEVELS_MAX)) begin
      p_wide = 32'(LEVELS_MAX);
    end else begin
      p_wide = cnt_wide;
    end
  end
  assign p_d = p_wide[CW-1:0];

  // Neighbour choice: lower one only if strictly closer (lo + hi > 2v)
  always_comb begin
    if (cmd_i.res_sel == RES_PICK_LO) begin
      lo_s = rd_s;
      hi_s = m_q;
    end else begin
      lo_s = m_q;
      hi_s = rd_s;
    end
  end
  assign pair_sum     = {{2{lo_s[VALUE_BITS-1]}}, lo_s} + {{2{hi_s[VALUE_BITS-1]}}, hi_s};
  assign twice_v      = {v_q[VALUE_BITS-1], v_q, 1'b0};
  assign lower_closer = pair_sum > twice_v;

  // Result select
  always_comb begin
    unique case (cmd_i.res_sel)
      RES_ZERO:    res_d = '0;
      RES_LAST:    res_d = last_idx[AW-1:0];
      RES_MID:     res_d = mid_q;
      RES_PICK_LO: res_d = lower_closer ? (mid_q - AW'(1)) : mid_q;
      RES_PICK_HI: res_d = lower_closer ? mid_q : (mid_q + AW'(1));
      default:     res_d = '0;
    endcase
  end

  // Status toward the controller
  assign mid_p1_wide          = (CW+1)'(mid_q) + (CW+1)'(1);
  assign status_o.v_le        = v_q <= rd_s;
  assign status_o.v_ge        = v_q >= rd_s;
  assign status_o.v_eq        = v_q == rd_s;
  assign status_o.v_lt        = v_q < rd_s;
  assign status_o.v_gt        = v_q > rd_s;
  assign status_o.i_lt_j      = i_q < j_q;
  assign status_o.mid_gt0     = mid_q != '0;
  assign status_o.mid_lt_last = mid_p1_wide < {1'b0, p_q};
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  // Control registers: count, bounds, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= 9'd256;
      p_q         <= CW'(1);
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) count_q <= cfg_data_i;
      if (cmd_i.load_query) p_q <= p_d;
      if (cmd_i.init_ij) begin
        i_q <= '0;
        j_q <= p_q;
      end
      if (cmd_i.set_j_mid)  j_q <= CW'(mid_q);
      if (cmd_i.set_i_mid1) i_q <= CW'(mid_q) + CW'(1);
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  assign res_wide = 32'(res_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_query) v_q   <= level_value_i;
    if (cmd_i.load_mid)   mid_q <= mid_d;
    if (cmd_i.save_m)     m_q   <= rd_s;
    if (cmd_i.res_load)   res_q <= res_d;
    if (cmd_i.out_load)   out_idx_q <= res_wide[7:0];
  end

  assign out_valid_o     = out_valid_q;
  assign nearest_index_o = out_idx_q;

`ifndef NO_ASSERTIONS
  // A result is never loaded over one that is still held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded while output stalled");

  // A probed midpoint lies inside the count in use
  a_mid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_mid |=> ({1'b0, mid_q} < (AW+1)'(p_q)))
    else $error("midpoint outside table in use");

  // Every found index lies below the count in use
  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |=> ((CW+1)'(res_q) < {1'b0, p_q}))
    else $error("result index not below count");

  // The upper search bound never exceeds the count
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.set_j_mid |=> (j_q <= p_q))
    else $error("upper bound above count");
`endif

endmodule

// ===== design/nearest_level_search.sv =====
// Top level of the nearest level search over an ascending table of levels.
//
// Channels: an input channel (in_valid_i/in_ready_o) carries opcode_i,
// entry_index_i and level_value_i; an output channel (out_valid_o/out_ready_i)
// carries nearest_index_o; a config channel (cfg_valid_i/cfg_ready_o) writes
// level_count from cfg_data_i and is always ready.
// A write transaction (opcode 0) stores one entry and gives no result.
// A query transaction (opcode 1) searches the table held in a single-port-read
// RAM with registered read data, at most one table read per cycle. Clamp
// checks read the first entry, then the last; each binary search step reads
// the midpoint, then, if it does not match, a neighbour where one exists. The
// result is loaded into the output register after the search ends; a new
// transaction is taken once the previous query has finished.
// Reset clears the controller and output valid and sets level_count to 256;
// table contents stay undefined until written.
// A stalled receiver holds the result in the output register; the block still
// takes the next transaction and only waits if a second result is ready.
module nearest_level_search #(
  parameter int LEVELS_MAX = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [7:0]            entry_index_i,
  input  logic [VALUE_BITS-1:0] level_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            nearest_index_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [8:0]            cfg_data_i
);
  import nls_pkg::*;

  nls_cmd_t    cmd;
  nls_status_t status;

  assign cfg_ready_o = 1'b1;

  nls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nls_datapath #(
    .LEVELS_MAX (LEVELS_MAX),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .entry_index_i   (entry_index_i),
    .level_value_i   (level_value_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .nearest_index_o (nearest_index_o)
  );

endmodule
